>>> hw/rtl/pkhm_pkg.sv
// Package for the pair-key hash map: sizes, defaults, register and request codes.
// Used by the sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none
package pkhm_pkg;
  localparam int NUM_BUCKETS_DEF  = 256;
  localparam int POOL_ENTRIES_DEF = 512;
  localparam int KEY_WIDTH_DEF    = 16;
  localparam int VALUE_WIDTH      = 32;
  localparam int CFG_WIDTH        = 9;
  localparam logic [CFG_WIDTH-1:0] BUCKET_COUNT_RESET = 9'd256;
  localparam logic [0:0] REG_BUCKET_COUNT = 1'b0;
  localparam logic REQ_SET = 1'b0;
  localparam logic REQ_GET = 1'b1;
endpackage
`default_nettype wire

>>> hw/rtl/pkhm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pkhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/pkhm_mod.sv
// Restoring modulo unit: one quotient bit per cycle, shared subtract/compare.
// Depends on pkhm_pkg only through the parent parameters.
`timescale 1ns / 1ps
`default_nettype none
module pkhm_mod #(
  parameter int SUM_WIDTH = 17,
  parameter int DIV_WIDTH = 9
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [SUM_WIDTH-1:0] dividend,
  input  wire logic [DIV_WIDTH-1:0] divisor,
  output logic                      done,
  output logic      [DIV_WIDTH-1:0] remainder
);
  localparam int CW = $clog2(SUM_WIDTH + 1);
  logic [SUM_WIDTH-1:0] shreg;
  logic [DIV_WIDTH-1:0] dvs;
  logic [DIV_WIDTH:0]   rem;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic [DIV_WIDTH:0]   trial;
  logic [DIV_WIDTH:0]   diff;

  assign trial = {rem[DIV_WIDTH-1:0], shreg[SUM_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};
  assign remainder = rem[DIV_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(SUM_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      rem   <= diff[DIV_WIDTH] ? trial : diff;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/pkhm_ctrl.sv
// Sequencer: hashes the key, walks the bucket chain, then reads, updates or appends.
// Depends on pkhm_pkg, pkhm_mod and pkhm_ram.
`timescale 1ns / 1ps
`default_nettype none
module pkhm_ctrl #(
  parameter int NUM_BUCKETS  = pkhm_pkg::NUM_BUCKETS_DEF,
  parameter int POOL_ENTRIES = pkhm_pkg::POOL_ENTRIES_DEF,
  parameter int KEY_WIDTH    = pkhm_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [pkhm_pkg::CFG_WIDTH-1:0]    bucket_count,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              req_type,
  input  wire logic [KEY_WIDTH-1:0]              key_i,
  input  wire logic [KEY_WIDTH-1:0]              key_j,
  input  wire logic signed [pkhm_pkg::VALUE_WIDTH-1:0] value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   found,
  output logic signed [pkhm_pkg::VALUE_WIDTH-1:0] read_value,
  output logic                                   pool_full
);
  localparam int VW = pkhm_pkg::VALUE_WIDTH;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam int DW = $clog2(NUM_BUCKETS + 1);
  localparam int SW = KEY_WIDTH + 1;
  localparam int DVW = (DW > pkhm_pkg::CFG_WIDTH) ? DW : pkhm_pkg::CFG_WIDTH;
  localparam int EW = 2 * KEY_WIDTH + VW + LW;
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_HASH  = 9'b000000010,
    S_HEAD  = 9'b000000100,
    S_HEADW = 9'b000001000,
    S_READ  = 9'b000010000,
    S_CMP   = 9'b000100000,
    S_LINK  = 9'b001000000,
    S_NEW   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic                 req_get;
  logic [KEY_WIDTH-1:0] ka, kb;
  logic [VW-1:0]        val;
  logic [BW-1:0]        bucket;
  logic [LW-1:0]        cur, tail, used;
  logic [PW:0]          steps;
  logic [NUM_BUCKETS-1:0] bvalid;

  logic [DVW-1:0] div_sat;
  logic           mod_start, mod_done;
  logic [DVW-1:0] mod_rem;

  logic           bt_we, pool_we;
  logic [BW-1:0]  bt_addr;
  logic [2*LW-1:0] bt_wdata, bt_rdata;
  logic [PW-1:0]  pool_addr;
  logic [EW-1:0]  pool_wdata, pool_rdata;

  logic [KEY_WIDTH-1:0] e_ka, e_kb;
  logic [VW-1:0]        e_val;
  logic [LW-1:0]        e_link;
  logic [LW-1:0]        b_head, b_tail;

  always_comb begin
    div_sat = DVW'(bucket_count);
    if (bucket_count == '0) begin
      div_sat = DVW'(1);
    end else if (DVW'(bucket_count) > DVW'(NUM_BUCKETS)) begin
      div_sat = DVW'(NUM_BUCKETS);
    end
  end

  pkhm_mod #(.SUM_WIDTH(SW), .DIV_WIDTH(DVW)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start),
    .dividend({1'b0, key_i} + {1'b0, key_j}), .divisor(div_sat),
    .done(mod_done), .remainder(mod_rem)
  );

  pkhm_ram #(.WIDTH(2 * LW), .DEPTH(1 << BW)) u_bucket (
    .clk(clk), .we(bt_we), .addr(bt_addr), .wdata(bt_wdata), .rdata(bt_rdata)
  );

  pkhm_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_pool (
    .clk(clk), .we(pool_we), .addr(pool_addr), .wdata(pool_wdata), .rdata(pool_rdata)
  );

  assign {e_ka, e_kb, e_val, e_link} = pool_rdata;
  assign b_head = bvalid[bucket] ? bt_rdata[2*LW-1:LW] : NIL;
  assign b_tail = bvalid[bucket] ? bt_rdata[LW-1:0] : NIL;
  assign in_stall  = (state != S_IDLE);
  assign mod_start = (state == S_IDLE) && in_valid;
  assign bt_addr   = bucket;

  always_comb begin
    bt_we      = 1'b0;
    bt_wdata   = '0;
    pool_we    = 1'b0;
    pool_addr  = cur[PW-1:0];
    pool_wdata = {ka, kb, val, NIL};
    case (state)
      S_READ: begin
        if (cur == NIL || steps == (PW + 1)'(POOL_ENTRIES)) begin
          pool_addr = tail[PW-1:0];
        end
      end
      S_CMP: begin
        if (e_ka == ka && e_kb == kb && !req_get) begin
          pool_we    = 1'b1;
          pool_wdata = {e_ka, e_kb, val, e_link};
        end
      end
      S_LINK: begin
        pool_addr  = tail[PW-1:0];
        pool_we    = 1'b1;
        pool_wdata = {e_ka, e_kb, e_val, used};
      end
      S_NEW: begin
        pool_addr = used[PW-1:0];
        pool_we   = 1'b1;
        bt_we     = 1'b1;
        bt_wdata  = {(tail == NIL) ? used : b_head, used};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      bvalid    <= '0;
      used      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_get <= req_type;
            ka      <= key_i;
            kb      <= key_j;
            val     <= value;
            state   <= S_HASH;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            bucket <= BW'(mod_rem);
            state  <= S_HEAD;
          end
        end
        S_HEAD: state <= S_HEADW;
        S_HEADW: begin
          cur   <= b_head;
          tail  <= b_tail;
          steps <= '0;
          state <= S_READ;
        end
        S_READ: begin
          if (cur == NIL || steps == (PW + 1)'(POOL_ENTRIES)) begin
            found      <= 1'b0;
            pool_full  <= 1'b0;
            read_value <= '1;
            if (req_get) begin
              state <= S_OUT;
            end else if (used == NIL) begin
              pool_full  <= 1'b1;
              read_value <= '0;
              state      <= S_OUT;
            end else begin
              read_value <= '0;
              state      <= (tail == NIL) ? S_NEW : S_LINK;
              if (tail != NIL) begin
                cur <= tail;
              end
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (e_ka == ka && e_kb == kb) begin
            found      <= 1'b1;
            pool_full  <= 1'b0;
            read_value <= req_get ? e_val : '0;
            state      <= S_OUT;
          end else begin
            cur   <= e_link;
            steps <= steps + 1'b1;
            state <= S_READ;
          end
        end
        S_LINK: begin
          if (cur == tail && pool_addr == tail[PW-1:0]) begin
            state <= S_NEW;
          end
        end
        S_NEW: begin
          bvalid[bucket] <= 1'b1;
          used           <= used + 1'b1;
          state          <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/pair_key_hash_map.sv
// Top level of the pair-key hash map: APB register and request sequencer.
// Depends on pkhm_pkg and pkhm_ctrl.
`timescale 1ns / 1ps
`default_nettype none
// A request is accepted in the idle state, then passes through the bit-serial
// modulo (17 key-sum bits, one per cycle, plus the done handoff), the bucket
// head read, a compare of each chain entry on the single pool RAM port, the
// chain-end check on a miss, the link of a new entry behind an existing tail,
// the append, and the presentation and handoff of the result word; the result
// word is held until taken and the input stays stalled until then.
// No clearing pass follows reset: bucket heads are marked empty by valid bits.
module pair_key_hash_map #(
  parameter int NUM_BUCKETS  = pkhm_pkg::NUM_BUCKETS_DEF,
  parameter int POOL_ENTRIES = pkhm_pkg::POOL_ENTRIES_DEF,
  parameter int KEY_WIDTH    = pkhm_pkg::KEY_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [KEY_WIDTH-1:0] key_i,
  input  wire logic [KEY_WIDTH-1:0] key_j,
  input  wire logic signed [pkhm_pkg::VALUE_WIDTH-1:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic signed [pkhm_pkg::VALUE_WIDTH-1:0] read_value,
  output logic             pool_full
);
  logic [pkhm_pkg::CFG_WIDTH-1:0] bucket_count;

  assign pready = 1'b1;
  assign prdata = (paddr[1] == pkhm_pkg::REG_BUCKET_COUNT) ? 32'(bucket_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= pkhm_pkg::BUCKET_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[1] == pkhm_pkg::REG_BUCKET_COUNT) begin
      bucket_count <= pwdata[pkhm_pkg::CFG_WIDTH-1:0];
    end
  end

  pkhm_ctrl #(
    .NUM_BUCKETS(NUM_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES), .KEY_WIDTH(KEY_WIDTH)
  ) u_ctrl (
    .clk(clk), .rst(rst), .bucket_count(bucket_count),
    .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
    .key_i(key_i), .key_j(key_j), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .found(found),
    .read_value(read_value), .pool_full(pool_full)
  );
endmodule
`default_nettype wire

>>> hw/rtl/pair_key_hash_map_chk.sv
// Port-level checker for the pair-key hash map, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none
module pair_key_hash_map_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        found,
  input wire logic [31:0] read_value,
  input wire logic        pool_full
);
  a_full_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(found && pool_full)) else $error("full and found together");
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pool_full) |-> (read_value == 32'd0)) else $error("full word nonzero");
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while word pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_value)))
    else $error("stalled word changed");
endmodule
bind pair_key_hash_map pair_key_hash_map_chk u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .found(found),
  .read_value(read_value), .pool_full(pool_full)
);
`default_nettype wire
